### design/mwia_pkg.sv
// shared types, constants and helpers of the mixed-width integer alu
`default_nettype none
package mwia_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DivDepth = DataW;

  typedef enum logic [3:0] {
    OpCmp = 4'd0,
    OpOr  = 4'd1,
    OpXor = 4'd2,
    OpAnd = 4'd3,
    OpAdd = 4'd4,
    OpSub = 4'd5,
    OpMul = 4'd6,
    OpDiv = 4'd7,
    OpShl = 4'd8,
    OpShr = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    Sz1 = 2'd0,
    Sz2 = 2'd1,
    Sz4 = 2'd2,
    Sz8 = 2'd3
  } size_e;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic             err;
    logic             is_div;
    logic             dz;
    logic             neg;
    logic [1:0]       nsz;
    logic             nsg;
  } side_t;

  function automatic logic [DataW-1:0] wmask(input logic [1:0] sz);
    logic [DataW-1:0] m;
    unique case (size_e'(sz))
      Sz1:     m = {{(DataW-8){1'b0}}, {8{1'b1}}};
      Sz2:     m = {{(DataW-16){1'b0}}, {16{1'b1}}};
      Sz4:     m = {{(DataW-32){1'b0}}, {32{1'b1}}};
      default: m = {DataW{1'b1}};
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] ext(input logic [DataW-1:0] v,
                                           input logic [1:0] sz, input logic s);
    logic [DataW-1:0] r;
    unique case (size_e'(sz))
      Sz1:     r = {{(DataW-8){s & v[7]}}, v[7:0]};
      Sz2:     r = {{(DataW-16){s & v[15]}}, v[15:0]};
      Sz4:     r = {{(DataW-32){s & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/mwia_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module mwia_div
  import mwia_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output logic      [DataW-1:0] quotient_o
);

  logic [DataW-1:0] rem_q [DivDepth];
  logic [DataW-1:0] quo_q [DivDepth];
  logic [DataW-1:0] dvs_q [DivDepth];
  logic [DataW-1:0] rem_d [DivDepth];
  logic [DataW-1:0] quo_d [DivDepth];

  for (genvar k = 0; k < DivDepth; k++) begin : g_stage
    logic [DataW-1:0] rem_in, quo_in, dvs_in;
    logic [DataW:0]   t, diff;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = dividend_i;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end
    always_comb begin
      t    = {rem_in, quo_in[DataW-1]};
      diff = t - {1'b0, dvs_in};
      if (!diff[DataW]) begin
        rem_d[k] = diff[DataW-1:0];
        quo_d[k] = {quo_in[DataW-2:0], 1'b1};
      end else begin
        rem_d[k] = t[DataW-1:0];
        quo_d[k] = {quo_in[DataW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d[k];
      quo_q[k] <= quo_d[k];
      dvs_q[k] <= dvs_in;
    end
  end

  assign quotient_o = quo_q[DivDepth-1];

endmodule
`default_nettype wire

### design/mixed_width_integer_alu_core.sv
// mixed-width integer alu with c-style promotion, fully pipelined
// a request passes the capture, promotion, operand, divider and output registers before done_o
// throughput: one request per cycle; busy is always low
// depth is set by the 64-stage divider, all operations share that path
// reset clears the valid bits only; the receiver cannot stall
`default_nettype none
module mixed_width_integer_alu_core
  import mwia_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [DataW-1:0] left_value_i,
  input  wire logic [1:0]       left_size_i,
  input  wire logic             left_is_signed_i,
  input  wire logic [DataW-1:0] right_value_i,
  input  wire logic [1:0]       right_size_i,
  input  wire logic             right_is_signed_i,
  input  wire logic [3:0]       operation_i,
  output logic                  done_o,
  output logic signed [DataW-1:0] result_o,
  output logic                  error_o
);

  assign busy = 1'b0;

  // stage 1: captured request
  logic             v1_q;
  logic [DataW-1:0] lv1_q, rv1_q;
  logic [1:0]       ls1_q, rs1_q;
  logic             lg1_q, rg1_q;
  logic [3:0]       op1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start & ~busy;
  end

  always_ff @(posedge clk_i) begin
    lv1_q <= left_value_i;
    rv1_q <= right_value_i;
    ls1_q <= left_size_i;
    rs1_q <= right_size_i;
    lg1_q <= left_is_signed_i;
    rg1_q <= right_is_signed_i;
    op1_q <= operation_i;
  end

  // stage 2: promoted operands
  logic             v2_q;
  logic [DataW-1:0] a2_q, b2_q, lx2_q, rx2_q;
  logic [DataW-1:0] a2_d, b2_d, lx2_d, rx2_d, mw;
  logic [1:0]       w2_q, w2_d;
  logic             sg2_q, sg2_d;
  logic [3:0]       op2_q;

  always_comb begin
    w2_d  = ls1_q;
    sg2_d = lg1_q;
    if (ls1_q < rs1_q) begin
      w2_d  = rs1_q;
      sg2_d = rg1_q;
    end else if (ls1_q == rs1_q) begin
      sg2_d = lg1_q & rg1_q;
    end
    mw    = wmask(w2_d);
    lx2_d = ext(lv1_q, ls1_q, lg1_q) & mw;
    rx2_d = ext(rv1_q, rs1_q, rg1_q) & mw;
    a2_d  = ext(lx2_d, w2_d, sg2_d);
    b2_d  = ext(rx2_d, w2_d, sg2_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    a2_q  <= a2_d;
    b2_q  <= b2_d;
    lx2_q <= lx2_d;
    rx2_q <= rx2_d;
    w2_q  <= w2_d;
    sg2_q <= sg2_d;
    op2_q <= op1_q;
  end

  // stage 3: simple results, multiplier partials, divider operands
  logic             v3_q, is_mul3_q, is_mul3_d;
  side_t            sd3_q, sd3_d;
  logic [DataW-1:0] p0_q, p0_d;
  logic [31:0]      p1_q, p2_q, p1_d, p2_d;
  logic [DataW-1:0] dnd_q, dvs_q, dnd_d, dvs_d, am;
  logic             neg_a, neg_b, big_sh;

  always_comb begin
    sd3_d.nsz = (w2_q < 2'(Sz4)) ? 2'(Sz4) : w2_q;
    sd3_d.nsg = (w2_q < 2'(Sz4)) ? 1'b1 : sg2_q;
    am        = wmask(sd3_d.nsz);
    neg_a     = sd3_d.nsg & a2_q[DataW-1];
    neg_b     = sd3_d.nsg & b2_q[DataW-1];
    big_sh    = |b2_q[DataW-1:6];
    dnd_d     = (neg_a ? (~a2_q + 1'b1) : a2_q) & am;
    dvs_d     = (neg_b ? (~b2_q + 1'b1) : b2_q) & am;
    sd3_d.neg = neg_a ^ neg_b;
    sd3_d.dz  = ~|(b2_q & am);
    p0_d      = DataW'(a2_q[31:0] * b2_q[31:0]);
    p1_d      = 32'(a2_q[31:0] * b2_q[63:32]);
    p2_d      = 32'(a2_q[63:32] * b2_q[31:0]);
    sd3_d.res    = '0;
    sd3_d.err    = 1'b0;
    sd3_d.is_div = 1'b0;
    is_mul3_d    = 1'b0;
    case (op2_q)
      OpCmp: begin
        if (sg2_q ? ($signed(a2_q) > $signed(b2_q)) : (a2_q > b2_q)) begin
          sd3_d.res = DataW'(1);
        end else if (a2_q != b2_q) begin
          sd3_d.res = '1;
        end
      end
      OpOr:  sd3_d.res = lx2_q | rx2_q;
      OpXor: sd3_d.res = lx2_q ^ rx2_q;
      OpAnd: sd3_d.res = lx2_q & rx2_q;
      OpAdd: sd3_d.res = ext(a2_q + b2_q, sd3_d.nsz, sd3_d.nsg);
      OpSub: sd3_d.res = ext(a2_q - b2_q, sd3_d.nsz, sd3_d.nsg);
      OpMul: is_mul3_d = 1'b1;
      OpDiv: sd3_d.is_div = 1'b1;
      OpShl: sd3_d.res = big_sh ? '0 : (a2_q << b2_q[5:0]);
      OpShr: begin
        if (sg2_q && a2_q[DataW-1]) begin
          sd3_d.res = big_sh ? '1 : ~((~a2_q) >> b2_q[5:0]);
        end else begin
          sd3_d.res = big_sh ? '0 : (a2_q >> b2_q[5:0]);
        end
      end
      default: sd3_d.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    sd3_q     <= sd3_d;
    is_mul3_q <= is_mul3_d;
    p0_q      <= p0_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    dnd_q     <= dnd_d;
    dvs_q     <= dvs_d;
  end

  // divider and the matching side line
  logic [DataW-1:0] quo;

  mwia_div u_div (
    .clk_i      (clk_i),
    .dividend_i (dnd_q),
    .divisor_i  (dvs_q),
    .quotient_o (quo)
  );

  logic  sv_q [DivDepth];
  side_t sd_q [DivDepth];
  side_t sd0_d;

  always_comb begin
    sd0_d = sd3_q;
    if (is_mul3_q) begin
      sd0_d.res = ext(p0_q + {p1_q + p2_q, 32'b0}, sd3_q.nsz, sd3_q.nsg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivDepth; k++) sv_q[k] <= 1'b0;
    end else begin
      sv_q[0] <= v3_q;
      for (int k = 1; k < DivDepth; k++) sv_q[k] <= sv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= sd0_d;
    for (int k = 1; k < DivDepth; k++) sd_q[k] <= sd_q[k-1];
  end

  // output stage
  side_t            st;
  logic [DataW-1:0] res_d;
  logic             err_d;

  always_comb begin
    st    = sd_q[DivDepth-1];
    res_d = st.res;
    err_d = st.err;
    if (st.is_div) begin
      err_d = st.dz;
      res_d = st.dz ? '0 : ext(st.neg ? (~quo + 1'b1) : quo, st.nsz, st.nsg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= sv_q[DivDepth-1];
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
    error_o  <= err_d;
  end

`ifndef ASSERT_OFF
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && error_o |-> result_o == '0)
    else $error("error with nonzero result");
  a_dz_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[DivDepth-1] && st.is_div && st.dz |=> done_o && error_o)
    else $error("divide by zero not flagged");
  a_done_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[DivDepth-1] |=> done_o)
    else $error("request lost at output");
`endif

endmodule
`default_nettype wire
